>>> rtl/core/lattice_block_partition_map_unit_defines.svh
// Assertion macros for the partition map unit.
`ifndef LATTICE_BLOCK_PARTITION_MAP_UNIT_DEFINES_SVH
`define LATTICE_BLOCK_PARTITION_MAP_UNIT_DEFINES_SVH
`ifndef SYNTH
`define LBPM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define LBPM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define LBPM_ASSERT_IMP(label, clk, rst, ante, cons)
`define LBPM_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/lbpm_pkg.sv
package lbpm_pkg;
   localparam int DIMS = 4;
   localparam int BORDER_WIDTH = 1;
   localparam int CW = 12;
   localparam int GW = 13;
   localparam int PW = 9;
   localparam int DLW = 26;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_SMALL = 2'd2;
   localparam logic [2:0] REG_EXT_T = 3'd0;
   localparam logic [2:0] REG_PROCS_T = 3'd4;
   localparam logic KIND_OWNER = 1'b0;
   localparam logic KIND_BLOCK = 1'b1;

   typedef struct packed {
      logic kind;
      logic [CW-1:0] coord_0;
      logic [CW-1:0] coord_1;
      logic [CW-1:0] coord_2;
      logic [CW-1:0] coord_3;
   } req_type;

   typedef struct packed {
      logic [CW-1:0] result_0;
      logic [CW-1:0] result_1;
      logic [CW-1:0] result_2;
      logic [CW-1:0] result_3;
      logic [GW-1:0] extent_0;
      logic [GW-1:0] extent_1;
      logic [GW-1:0] extent_2;
      logic [GW-1:0] extent_3;
      logic origin_parity;
      logic [1:0] status;
   } rsp_type;

   // per-dimension partition constants
   typedef struct packed {
      logic [GW-1:0] g;
      logic [PW-1:0] p;
      logic [GW-1:0] d;
      logic [PW-1:0] r;
      logic [DLW:0] inv_d;
      logic [DLW:0] inv_d1;
      logic [GW+PW-1:0] big;
      logic tiny;
   } dim_type;
endpackage

>>> rtl/core/lbpm_if.sv
interface lbpm_req_if import lbpm_pkg::*; ();
   logic valid;
   logic ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface lbpm_rsp_if import lbpm_pkg::*; ();
   logic valid;
   logic ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/lattice_block_partition_map_unit.sv
// channel | dir | beat
// req     | in  | kind, coord_0..3
// rsp     | out | result_0..3, extent_0..3, origin_parity, status
// csr     | in  | index 0..7, 13-bit data
// One beat per cycle through the quotient pipeline unless rsp stalls or the constants rebuild.
// A csr write rebuilds the per-dimension constants serially, one dimension at a time
// (all of them after reset); req is held off while they rebuild.
// Stalls on rsp freeze all stages; nothing is lost.
`include "lattice_block_partition_map_unit_defines.svh"
module lattice_block_partition_map_unit import lbpm_pkg::*; (
   input  logic clock,
   input  logic reset,
   lbpm_req_if.sink req,
   lbpm_rsp_if.source rsp,
   input  logic csr_wr_en,
   input  logic [2:0] csr_index,
   input  logic [GW-1:0] csr_wr_data
);
   logic [GW-1:0] gext_ff [DIMS];
   logic [PW-1:0] pcnt_ff [DIMS];
   logic [DIMS-1:0] dirty_ff;
   dim_type dim_ff [DIMS];
   logic [1:0] sdim_ff;
   logic busy_ff;
   logic sdone;
   dim_type sdim_out;
   logic [GW-1:0] gcl;
   logic [PW-1:0] pcl;

   always_comb begin
      gcl = gext_ff[sdim_ff];
      if (gcl == '0) gcl = GW'(1);
      else if (gcl > GW'(4096)) gcl = GW'(4096);
      pcl = pcnt_ff[sdim_ff];
      if (pcl == '0) pcl = PW'(1);
      else if (pcl > PW'(256)) pcl = PW'(256);
   end

   lbpm_setup u_setup (
      .clock(clock), .reset(reset), .g_in(gcl), .p_in(pcl),
      .start_in(!busy_ff && dirty_ff[sdim_ff] && !csr_wr_en),
      .dim_out(sdim_out), .done_out(sdone)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIMS; i++) begin
            gext_ff[i] <= GW'(8);
            pcnt_ff[i] <= PW'(1);
         end
         dirty_ff <= '1;
         sdim_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         if (sdone) begin
            dim_ff[sdim_ff] <= sdim_out;
            busy_ff <= 1'b0;
         end else if (!busy_ff && dirty_ff[sdim_ff] && !csr_wr_en) begin
            busy_ff <= 1'b1;
            dirty_ff[sdim_ff] <= 1'b0;
         end else if (!busy_ff) sdim_ff <= sdim_ff + 1'b1;
         if (csr_wr_en) begin
            if (csr_index < REG_PROCS_T) begin
               gext_ff[csr_index[1:0]] <= csr_wr_data;
               dirty_ff[csr_index[1:0]] <= 1'b1;
            end else begin
               pcnt_ff[csr_index[1:0]] <= csr_wr_data[PW-1:0];
               dirty_ff[csr_index[1:0]] <= 1'b1;
            end
         end
      end
   end

   logic settled;
   assign settled = (dirty_ff == '0) && !busy_ff;

   // pipeline
   logic adv;
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   assign adv = !v4_ff || rsp.ready;
   assign req.ready = adv && settled;

   logic k1_ff, k2_ff, k3_ff;
   logic [1:0] st1_ff, st2_ff, st3_ff;
   logic [CW-1:0] c1_ff [DIMS];
   logic [CW-1:0] c2_ff [DIMS];
   logic [DLW+CW-1:0] pa_ff [DIMS];
   logic lo2_ff [DIMS];
   logic [CW-1:0] q3_ff [DIMS];
   logic [GW+PW-1:0] pr2_ff [DIMS];
   logic [GW-1:0] ex2_ff [DIMS];
   logic [GW+PW-1:0] o3_ff [DIMS];
   logic [GW-1:0] ex3_ff [DIMS];
   rsp_type out_ff;
   rsp_type out_in;

   logic [CW-1:0] cin [DIMS];
   assign cin[0] = req.data.coord_0;
   assign cin[1] = req.data.coord_1;
   assign cin[2] = req.data.coord_2;
   assign cin[3] = req.data.coord_3;

   logic [1:0] st_in;
   always_comb begin
      st_in = ST_OK;
      for (int i = 0; i < DIMS; i++)
         if ((req.data.kind == KIND_BLOCK) ? ({1'b0, cin[i]} >= GW'(dim_ff[i].p))
                                           : ({1'b0, cin[i]} >= dim_ff[i].g)) st_in = ST_RANGE;
      if (st_in == ST_OK)
         for (int i = 0; i < DIMS; i++) if (dim_ff[i].tiny) st_in = ST_SMALL;
   end

   logic [CW-1:0] qv [DIMS];
   always_comb begin
      for (int i = 0; i < DIMS; i++) begin
         logic [DLW+CW-1:0] pv;
         logic [GW+PW:0] back;
         logic [GW-1:0] dv;
         pv = pa_ff[i];
         dv = lo2_ff[i] ? dim_ff[i].d + 1'b1 : dim_ff[i].d;
         qv[i] = pv[DLW+CW-1:DLW];
         back = (GW+PW+1)'(qv[i] * dv);
         if (back > (GW+PW+1)'(c2_ff[i])) qv[i] = qv[i] - 1'b1;
      end
   end

   always_comb begin
      out_in = '0;
      out_in.status = st3_ff;
      if (st3_ff == ST_OK) begin
         if (k3_ff == KIND_BLOCK) begin
            out_in.result_0 = o3_ff[0][CW-1:0];
            out_in.result_1 = o3_ff[1][CW-1:0];
            out_in.result_2 = o3_ff[2][CW-1:0];
            out_in.result_3 = o3_ff[3][CW-1:0];
            out_in.extent_0 = ex3_ff[0];
            out_in.extent_1 = ex3_ff[1];
            out_in.extent_2 = ex3_ff[2];
            out_in.extent_3 = ex3_ff[3];
            out_in.origin_parity = o3_ff[0][0] ^ o3_ff[1][0] ^ o3_ff[2][0] ^ o3_ff[3][0];
         end else begin
            out_in.result_0 = q3_ff[0];
            out_in.result_1 = q3_ff[1];
            out_in.result_2 = q3_ff[2];
            out_in.result_3 = q3_ff[3];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req.valid && settled;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         k1_ff <= req.data.kind;
         st1_ff <= st_in;
         for (int i = 0; i < DIMS; i++) c1_ff[i] <= cin[i];
         k2_ff <= k1_ff;
         st2_ff <= st1_ff;
         for (int i = 0; i < DIMS; i++) begin
            logic lo;
            logic [CW-1:0] x;
            lo = (GW+PW)'(c1_ff[i]) < dim_ff[i].big;
            x = lo ? c1_ff[i] : CW'((GW+PW)'(c1_ff[i]) - dim_ff[i].big);
            lo2_ff[i] <= lo;
            c2_ff[i] <= x;
            pa_ff[i] <= (DLW+CW)'(x * (lo ? dim_ff[i].inv_d1 : dim_ff[i].inv_d));
            if ({4'd0, c1_ff[i][PW-1:0]} < {4'd0, dim_ff[i].r} && c1_ff[i][CW-1:PW] == '0) begin
               pr2_ff[i] <= (GW+PW)'(c1_ff[i] * (dim_ff[i].d + 1'b1));
               ex2_ff[i] <= dim_ff[i].d + 1'b1;
            end else begin
               pr2_ff[i] <= (GW+PW)'(c1_ff[i] * dim_ff[i].d) + (GW+PW)'(dim_ff[i].r);
               ex2_ff[i] <= dim_ff[i].d;
            end
         end
         k3_ff <= k2_ff;
         st3_ff <= st2_ff;
         for (int i = 0; i < DIMS; i++) begin
            if (lo2_ff[i]) q3_ff[i] <= qv[i];
            else if (dim_ff[i].d == '0) q3_ff[i] <= '0;
            else q3_ff[i] <= CW'(qv[i] + CW'(dim_ff[i].r));
            o3_ff[i] <= pr2_ff[i];
            ex3_ff[i] <= ex2_ff[i];
         end
         out_ff <= out_in;
      end
   end

   assign rsp.valid = v4_ff;
   assign rsp.data = out_ff;

   `LBPM_ASSERT_IMP(a_no_accept_unsettled, clock, reset, req.ready, settled)
   `LBPM_ASSERT_NXT(a_stall_holds, clock, reset, v4_ff && !rsp.ready, v4_ff)
   `LBPM_ASSERT_IMP(a_status_code, clock, reset, v4_ff, out_ff.status != 2'd3)
   `LBPM_ASSERT_IMP(a_err_zero, clock, reset, v4_ff && out_ff.status != ST_OK,
      out_ff.result_0 == '0 && out_ff.origin_parity == 1'b0)
endmodule

>>> rtl/core/lbpm_setup.sv
module lbpm_setup import lbpm_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic [GW-1:0] g_in,
   input  logic [PW-1:0] p_in,
   input  logic start_in,
   output dim_type dim_out,
   output logic done_out
);
   typedef enum logic [1:0] {S_IDLE, S_DIV, S_INV, S_DONE} state_type;
   state_type state_ff;
   logic [4:0] step_ff;
   logic [GW-1:0] rem_ff, quo_ff;
   logic [DLW:0] irem_ff, irem1_ff;
   logic [DLW-1:0] inv_ff, inv1_ff;
   logic [GW-1:0] d1;
   logic [GW:0] trial;
   logic [DLW:0] it, it1;
   assign d1 = quo_ff + 1'b1;
   assign trial = {rem_ff, g_in[GW-1-step_ff[3:0]]};
   assign it = {irem_ff[DLW-1:0], 1'b1};
   assign it1 = {irem1_ff[DLW-1:0], 1'b1};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (start_in) begin
               state_ff <= S_DIV;
               step_ff <= '0;
               rem_ff <= '0;
               quo_ff <= '0;
            end
            S_DIV: begin
               if (trial >= {5'd0, p_in}) begin
                  rem_ff <= GW'(trial - {5'd0, p_in});
                  quo_ff <= {quo_ff[GW-2:0], 1'b1};
               end else begin
                  rem_ff <= trial[GW-1:0];
                  quo_ff <= {quo_ff[GW-2:0], 1'b0};
               end
               if (step_ff == 5'(GW-1)) begin
                  state_ff <= S_INV;
                  step_ff <= '0;
                  irem_ff <= '0;
                  irem1_ff <= '0;
               end else step_ff <= step_ff + 1'b1;
            end
            S_INV: begin
               // floor((2^DLW - 1) / x) built bit by bit
               if (quo_ff != '0 && it >= (DLW+1)'(quo_ff)) begin
                  irem_ff <= it - (DLW+1)'(quo_ff);
                  inv_ff <= {inv_ff[DLW-2:0], 1'b1};
               end else begin
                  irem_ff <= it;
                  inv_ff <= {inv_ff[DLW-2:0], 1'b0};
               end
               if (it1 >= (DLW+1)'(d1)) begin
                  irem1_ff <= it1 - (DLW+1)'(d1);
                  inv1_ff <= {inv1_ff[DLW-2:0], 1'b1};
               end else begin
                  irem1_ff <= it1;
                  inv1_ff <= {inv1_ff[DLW-2:0], 1'b0};
               end
               if (step_ff == 5'(DLW-1)) state_ff <= S_DONE;
               else step_ff <= step_ff + 1'b1;
            end
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // quotients use floor(x*M)>>DLW with M=ceil(2^DLW/d) and a final fix-up
   always_comb begin
      dim_out.g = g_in;
      dim_out.p = p_in;
      dim_out.d = quo_ff;
      dim_out.r = rem_ff[PW-1:0];
      dim_out.inv_d = (DLW+1)'(inv_ff) + 1'b1;
      dim_out.inv_d1 = (DLW+1)'(inv1_ff) + 1'b1;
      dim_out.big = (GW+PW)'(rem_ff[PW-1:0] * d1);
      dim_out.tiny = (p_in > 9'd1) && (quo_ff <= GW'(2*BORDER_WIDTH));
   end
   assign done_out = (state_ff == S_DONE);
endmodule
